// ----- rtl/core/uniform_window_marker_defines.svh -----
// Assertion macros for the uniform window marker core.
// Included by the top level; no other dependencies.
`ifndef UNIFORM_WINDOW_MARKER_DEFINES_SVH
`define UNIFORM_WINDOW_MARKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define UWM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define UWM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/uwm_pkg.sv -----
// Shared types, widths and constants of the uniform window marker.
// No dependencies; imported by every module of the core.
package uwm_pkg;

    // Default size limits, handed to the top level parameters
    localparam int UWM_MAX_ROW_WIDTH = 256;
    localparam int UWM_MAX_RADIUS    = 4;

    // Field and register widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int CELL_W      = 8;
    localparam int INDEX_W     = 16;
    localparam int DIM_W       = 9;
    localparam int RADIUS_W    = 3;
    localparam int FRAME_W     = 2 * DIM_W;
    localparam int SPAN_W      = 12;
    localparam int POS_W       = 24;
    localparam int RUN_W       = 4;

    // Run length saturates here; any window side (at most 14) fits below it
    localparam logic [RUN_W-1:0] RUN_SAT   = '1;
    localparam logic [POS_W-1:0] POS_LIMIT = '1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [DIM_W-1:0]    ROW_WIDTH_RESET = 9'd256;
    localparam logic [DIM_W-1:0]    ROW_COUNT_RESET = 9'd256;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET    = 3'd4;
    localparam logic                ENABLE_RESET    = 1'b1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ROW_WIDTH     = 2'd0,
        CFG_ROW_COUNT     = 2'd1,
        CFG_WINDOW_RADIUS = 2'd2,
        CFG_ENABLE        = 2'd3
    } cfg_index_t;

    // Effective frame geometry, derived from the registers
    typedef struct packed {
        logic [DIM_W-1:0]    x;         // clamped row width
        logic [RADIUS_W-1:0] r;         // clamped radius
        logic [FRAME_W-1:0]  frame;     // cells per frame
        logic [SPAN_W-1:0]   xr;        // x * r
        logic [SPAN_W-1:0]   lag;       // (r-1)*x + r-1
        logic [FRAME_W-1:0]  fmx;       // frame - x*r
        logic                too_small; // frame too small for any mark
        logic                enable;
    } geometry_t;

    // One history entry: stored cell and the run of equal cells ending at it
    typedef struct packed {
        logic [CELL_W-1:0] value;
        logic [RUN_W-1:0]  run;
    } hist_word_t;

    // One classified cell travelling from front to back
    typedef struct packed {
        logic               emit;
        logic               elig;
        logic [INDEX_W-1:0] index;
        hist_word_t         word;
    } cell_entry_t;

    typedef struct packed {
        logic [QCOUNT_W-1:0] count;
        logic                full;
        logic                empty;
    } q_status_t;

endpackage

// ----- rtl/core/uwm_front.sv -----
// Front end: accepts cells, tracks the raster position and horizontal runs,
// and classifies each beat for the back end. Depends on uwm_pkg.
module uwm_front import uwm_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  geometry_t           geo,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CELL_W-1:0]   s_cell_value,
    input  logic                s_first_of_frame,
    input  logic                q_full,
    output logic                push,
    output cell_entry_t         push_entry
);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CELL_W-1:0] prev_val_reg;
    logic [RUN_W-1:0]  prev_run_reg;

    logic [POS_W-1:0]  p;
    logic [POS_W-1:0]  rel;
    logic [CELL_W-1:0] stored;
    logic [CELL_W-1:0] pv;
    logic [RUN_W-1:0]  pr;
    logic [RUN_W-1:0]  run;
    logic              has_lag;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;

    // Classify the incoming beat
    always_comb begin
        p      = s_first_of_frame ? '0 : pos_reg;
        stored = (p < POS_W'(geo.frame)) ? s_cell_value : '0;
        // Cells before index zero read as zero, so a frame opens on a long zero run
        pv = (p == '0) ? '0 : prev_val_reg;
        pr = (p == '0) ? RUN_SAT : prev_run_reg;
        if (stored == pv) begin
            run = (pr == RUN_SAT) ? RUN_SAT : pr + 1'b1;
        end else begin
            run = RUN_W'(1);
        end
        has_lag = p >= POS_W'(geo.lag);
        rel     = p - POS_W'(geo.lag);

        push_entry.emit = geo.enable && has_lag && (rel < POS_W'(geo.frame));
        push_entry.elig = !geo.too_small && (rel >= POS_W'(geo.xr)) &&
                          (rel < POS_W'(geo.fmx));
        push_entry.index      = rel[INDEX_W-1:0];
        push_entry.word.value = stored;
        push_entry.word.run   = run;

        pos_next = (p == POS_LIMIT) ? POS_LIMIT : p + 1'b1;
    end

    // Advance position on every accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else if (push) begin
            pos_reg <= pos_next;
        end
    end

    // Hold the last stored cell and its run
    always_ff @(posedge aclk) begin
        if (push) begin
            prev_val_reg <= stored;
            prev_run_reg <= run;
        end
    end

endmodule

// ----- rtl/core/uwm_queue.sv -----
// Short FIFO of classified cells between front and back.
// Depends on uwm_pkg.
module uwm_queue import uwm_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  cell_entry_t push_entry,
    input  logic        pop,
    output logic        head_valid,
    output cell_entry_t head_entry,
    output q_status_t   status
);

    cell_entry_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   head_reg, tail_reg;
    logic [QCOUNT_W-1:0] count_reg;
    logic                do_push, do_pop;

    assign status.count = count_reg;
    assign status.full  = count_reg == QCOUNT_W'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign head_valid   = !status.empty;
    assign head_entry   = entry_reg[head_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;

    // Advance pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                tail_reg <= (tail_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            end
            if (do_pop) begin
                head_reg <= (head_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the pushed beat
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[tail_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/core/uwm_back.sv -----
// Back end: cell history line buffers, vertical window check and the
// result register. Depends on uwm_pkg.
module uwm_back import uwm_pkg::*; #(
    parameter int MaxRowWidth = UWM_MAX_ROW_WIDTH,
    parameter int MaxRadius   = UWM_MAX_RADIUS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  geometry_t          geo,
    input  logic               head_valid,
    input  cell_entry_t        head_entry,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [INDEX_W-1:0] m_cell_index,
    output logic [CELL_W-1:0]  m_mark_value
);

    localparam int HistDepth = 1 << $clog2(2 * MaxRadius * MaxRowWidth);
    localparam int AddrW     = $clog2(HistDepth);
    localparam int Taps      = 2 * MaxRadius - 1;

    logic [AddrW-1:0]   wptr_reg;
    logic               s1_valid_reg;
    cell_entry_t        s1_entry_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [CELL_W-1:0]  out_mark_reg;

    hist_word_t         win [Taps + 1];
    logic [CELL_W-1:0]  center;
    logic               uniform;
    logic [CELL_W-1:0]  mark;
    logic               s1_go;

    // Drain stage one when its result has room or needs no output
    assign s1_go = s1_valid_reg && (!s1_entry_reg.emit || !out_valid_reg || m_ready);
    assign pop   = head_valid && (!s1_valid_reg || s1_go);

    // Row m of the window ends m rows back from the newest cell
    assign win[0] = s1_entry_reg.word;

    for (genvar m = 1; m <= Taps; m++) begin : g_tap
        hist_word_t       hist_mem [HistDepth];
        hist_word_t       tap_reg;
        logic [AddrW-1:0] rd_addr;

        assign rd_addr = wptr_reg - AddrW'(32'(m) * 32'(geo.x));
        assign win[m]  = tap_reg;

        // Write the newest cell, read the one m rows back
        always_ff @(posedge aclk) begin
            if (pop) begin
                hist_mem[wptr_reg] <= head_entry.word;
                tap_reg            <= hist_mem[rd_addr];
            end
        end
    end

    // Check that every window row is a full run of the center value
    always_comb begin
        center  = '0;
        uniform = 1'b1;
        for (int m = 0; m <= Taps; m++) begin
            if (m == int'(geo.r) - 1) begin
                center = win[m].value;
            end
        end
        for (int m = 0; m <= Taps; m++) begin
            if (m < 2 * int'(geo.r)) begin
                if ((int'(win[m].run) < 2 * int'(geo.r)) || (win[m].value != center)) begin
                    uniform = 1'b0;
                end
            end
        end
        mark = (s1_entry_reg.elig && uniform) ? center : '0;
    end

    // Advance write pointer, stage one and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go && s1_entry_reg.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load stage one and result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_entry_reg <= head_entry;
        end
        if (s1_go && s1_entry_reg.emit) begin
            out_index_reg <= s1_entry_reg.index;
            out_mark_reg  <= mark;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_cell_index = out_index_reg;
    assign m_mark_value = out_mark_reg;

endmodule

// ----- rtl/core/uniform_window_marker.sv -----
// Top level of the uniform window marker: configuration registers,
// geometry derivation, front, queue and back. Depends on uwm_pkg and the defines header.
`include "uniform_window_marker_defines.svh"

// The block takes one grid cell per clock on s_ while its queue has room and,
// once the window of cell i is complete (when cell i+(R-1)*row_width+R-1
// arrives), returns one mark per in-frame cell on m_ (nothing while enable is
// 0, nothing for guard cells). Sustained rate is one cell per cycle while
// m_ready stays high. Each accepted cell costs one write and one read in each
// of the 2*MaxRadius-1 history line buffers, which set that rate. History is
// not cleared after reset, so there is no startup pass; cells are accepted from
// the first cycle out of reset. Register writes take effect at the next cycle;
// the user must keep them to idle periods only; the block does not enforce it.
module uniform_window_marker import uwm_pkg::*; #(
    parameter int MaxRowWidth = UWM_MAX_ROW_WIDTH,
    parameter int MaxRadius   = UWM_MAX_RADIUS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [CELL_W-1:0]      s_cell_value,
    input  logic                   s_first_of_frame,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [INDEX_W-1:0]     m_cell_index,
    output logic [CELL_W-1:0]      m_mark_value
);

    logic [DIM_W-1:0]    row_width_reg, row_width_next;
    logic [DIM_W-1:0]    row_count_reg, row_count_next;
    logic [RADIUS_W-1:0] radius_reg, radius_next;
    logic                enable_reg, enable_next;

    logic [DIM_W-1:0]    x_eff, y_eff;
    logic [RADIUS_W-1:0] r_eff;
    geometry_t           geo_reg, geo_next;

    logic        push, pop, head_valid;
    cell_entry_t push_entry, head_entry;
    q_status_t   q_stat;

    // Apply reset or a register write
    always_comb begin
        row_width_next = row_width_reg;
        row_count_next = row_count_reg;
        radius_next    = radius_reg;
        enable_next    = enable_reg;
        if (!aresetn) begin
            row_width_next = ROW_WIDTH_RESET;
            row_count_next = ROW_COUNT_RESET;
            radius_next    = RADIUS_RESET;
            enable_next    = ENABLE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_wr_index))
                CFG_ROW_WIDTH:     row_width_next = cfg_wr_data[DIM_W-1:0];
                CFG_ROW_COUNT:     row_count_next = cfg_wr_data[DIM_W-1:0];
                CFG_WINDOW_RADIUS: radius_next    = cfg_wr_data[RADIUS_W-1:0];
                CFG_ENABLE:        enable_next    = cfg_wr_data[0];
            endcase
        end
    end

    // Clamp the registers and derive the frame geometry
    always_comb begin
        if (row_width_next == '0) begin
            x_eff = DIM_W'(1);
        end else if (32'(row_width_next) > 32'(MaxRowWidth)) begin
            x_eff = DIM_W'(MaxRowWidth);
        end else begin
            x_eff = row_width_next;
        end
        y_eff = (row_count_next == '0) ? DIM_W'(1) : row_count_next;
        if (radius_next == '0) begin
            r_eff = RADIUS_W'(1);
        end else if (32'(radius_next) > 32'(MaxRadius)) begin
            r_eff = RADIUS_W'(MaxRadius);
        end else begin
            r_eff = radius_next;
        end

        geo_next.x         = x_eff;
        geo_next.r         = r_eff;
        geo_next.frame     = FRAME_W'(x_eff) * FRAME_W'(y_eff);
        geo_next.xr        = SPAN_W'(x_eff) * SPAN_W'(r_eff);
        geo_next.lag       = SPAN_W'(x_eff) * SPAN_W'(r_eff - 1'b1) + SPAN_W'(r_eff - 1'b1);
        geo_next.fmx       = geo_next.frame - FRAME_W'(geo_next.xr);
        geo_next.too_small = FRAME_W'({geo_next.xr, 1'b0}) > geo_next.frame;
        geo_next.enable    = enable_next;
    end

    // Hold configuration and derived geometry
    always_ff @(posedge aclk) begin
        row_width_reg <= row_width_next;
        row_count_reg <= row_count_next;
        radius_reg    <= radius_next;
        enable_reg    <= enable_next;
        geo_reg       <= geo_next;
    end

    uwm_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .geo              (geo_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cell_value     (s_cell_value),
        .s_first_of_frame (s_first_of_frame),
        .q_full           (q_stat.full),
        .push             (push),
        .push_entry       (push_entry)
    );

    uwm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .status     (q_stat)
    );

    uwm_back #(
        .MaxRowWidth (MaxRowWidth),
        .MaxRadius   (MaxRadius)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .geo          (geo_reg),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_cell_index (m_cell_index),
        .m_mark_value (m_mark_value)
    );

    // Queue bookkeeping stays consistent with front and back
    `UWM_ASSERT_IMP(a_pop_not_empty, aclk, aresetn, pop, !q_stat.empty, "pop from empty queue")
    `UWM_ASSERT_NXT(a_push_counts, aclk, aresetn, push && !pop, q_stat.count == $past(q_stat.count) + 1'b1, "queue count missed a push")
    `UWM_ASSERT_IMP(a_full_stalls, aclk, aresetn, q_stat.full, !s_ready, "input accepted into full queue")

endmodule

// ----- dv/uniform_window_marker_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for uniform_window_marker: directed frames, then random
// raster frames with bursty input and a stalling output. Depends on uwm_pkg and the RTL.
module uniform_window_marker_tb;
    import uwm_pkg::*;

    // Cell history depth: 2*UWM_MAX_RADIUS rows of the widest row
    localparam int          HIST_SLOTS   = 2 * UWM_MAX_RADIUS * UWM_MAX_ROW_WIDTH;
    localparam int unsigned POS_SAT      = 32'h00FF_FFFF;
    localparam int unsigned RANDOM_CELLS = 1300;
    localparam int          DRAIN_CYCLES = 16;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int          MAX_REPORTS  = 10;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [CELL_W-1:0]  value;
    } mark_t;

    logic                   aclk             = 1'b0;
    logic                   aresetn          = 1'b0;
    logic                   cfg_wr_en        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index     = CFG_ROW_WIDTH;
    logic [CFG_DATA_W-1:0]  cfg_wr_data      = '0;
    logic                   s_valid          = 1'b0;
    logic [CELL_W-1:0]      s_cell_value     = '0;
    logic                   s_first_of_frame = 1'b0;
    logic                   m_ready          = 1'b0;
    logic                   s_ready;
    logic                   m_valid;
    logic [INDEX_W-1:0]     m_cell_index;
    logic [CELL_W-1:0]      m_mark_value;

    // Predictor state: recent cells, frame position and register copies
    logic [CELL_W-1:0]   cell_store [HIST_SLOTS];
    logic [10:0]         store_wr      = '0;
    int unsigned         next_pos      = 0;
    logic [DIM_W-1:0]    row_width_q   = ROW_WIDTH_RESET;
    logic [DIM_W-1:0]    row_count_q   = ROW_COUNT_RESET;
    logic [RADIUS_W-1:0] radius_q      = RADIUS_RESET;
    logic                enable_q      = ENABLE_RESET;
    mark_t               pending_marks [$];

    int          mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned burst_left     = 0;
    int unsigned cells_sent     = 0;
    int unsigned rx_mode        = 0;
    int unsigned rx_left        = 0;

    uniform_window_marker DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cell_value     (s_cell_value),
        .s_first_of_frame (s_first_of_frame),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cell_index     (m_cell_index),
        .m_mark_value     (m_mark_value)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Cell stored 'back' beats before the newest one; the store wraps at 2048
    function automatic logic [CELL_W-1:0] stored_back(logic [10:0] newest, int unsigned back);
        logic [10:0] slot;
        slot = newest - back[10:0];
        return cell_store[slot];
    endfunction

    // Store one accepted cell and queue the mark it completes, if any
    function automatic void predict_cell(logic [CELL_W-1:0] v, logic first);
        int unsigned       x, y, r, frame, p, lag, i;
        int                idx;
        logic [10:0]       newest;
        logic [CELL_W-1:0] center, cv, mark;
        logic              same;
        mark_t             m;
        x = (row_width_q == 0) ? 1 :
            (row_width_q > UWM_MAX_ROW_WIDTH) ? UWM_MAX_ROW_WIDTH : row_width_q;
        y = (row_count_q == 0) ? 1 : row_count_q;
        r = (radius_q == 0) ? 1 : (radius_q > UWM_MAX_RADIUS) ? UWM_MAX_RADIUS : radius_q;
        frame = x * y;
        p = first ? 0 : next_pos;

        // Guard cells past the frame end are stored as zero
        newest = store_wr;
        cell_store[newest] = (p < frame) ? v : '0;
        store_wr = store_wr + 1'b1;
        next_pos = (p < POS_SAT) ? p + 1 : POS_SAT;

        if (!enable_q) return;
        lag = (r - 1) * x + (r - 1);
        if (p < lag) return;
        i = p - lag;
        if (i >= frame) return;

        // Window rows wrap across row ends; cells before index 0 read as zero
        mark = '0;
        if (2 * x * r <= frame && i >= x * r && i < frame - x * r) begin
            center = stored_back(newest, lag);
            same = 1'b1;
            for (int j = -int'(r); j < int'(r); j++) begin
                for (int d = -int'(r); d < int'(r); d++) begin
                    idx = int'(i) + j * int'(x) + d;
                    cv = (idx >= 0) ? stored_back(newest, int'(p) - idx) : '0;
                    if (cv != center) same = 1'b0;
                end
            end
            if (same) mark = center;
        end
        m.index = i[INDEX_W-1:0];
        m.value = mark;
        pending_marks.push_back(m);
    endfunction

    task automatic note_mismatch(string what, mark_t want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s: expected index %0d mark %0d, got index %0d mark %0d",
                     $realtime, what, want.index, want.value, m_cell_index, m_mark_value);
    endtask

    // Send one cell; the sender runs in bursts with idle gaps between them
    task automatic send_cell(logic [CELL_W-1:0] v, logic first);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        burst_left--;
        s_valid          <= 1'b1;
        s_cell_value     <= v;
        s_first_of_frame <= first;
        do @(posedge aclk); while (!s_ready);
        predict_cell(v, first);
        cells_sent++;
    endtask

    // Hold the input until every queued mark is out, then let the pipe settle
    task automatic wait_for_marks();
        s_valid <= 1'b0;
        while (pending_marks.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_ROW_WIDTH:     row_width_q = data;
            CFG_ROW_COUNT:     row_count_q = data;
            CFG_WINDOW_RADIUS: radius_q    = data[RADIUS_W-1:0];
            CFG_ENABLE:        enable_q    = data[0];
            default: ;
        endcase
    endtask

    // Reprogram all registers once the block has gone idle
    task automatic apply_config(logic [DIM_W-1:0] width, logic [DIM_W-1:0] count,
                                logic [RADIUS_W-1:0] radius, logic en);
        wait_for_marks();
        write_reg(CFG_ROW_WIDTH, width);
        write_reg(CFG_ROW_COUNT, count);
        write_reg(CFG_WINDOW_RADIUS, CFG_DATA_W'(radius));
        write_reg(CFG_ENABLE, CFG_DATA_W'(en));
        cfg_wr_en <= 1'b0;
    endtask

    // 3x4 frame, radius 1: edge cells see zeros before index 0, one zero cell
    // breaks nearby windows, one guard cell past the end
    task automatic test_edge_windows();
        apply_config(9'd3, 9'd4, 3'd1, 1'b1);
        send_cell(8'hFF, 1'b1);
        for (int k = 1; k < 12; k++)
            send_cell((k == 7) ? 8'h00 : 8'hFF, 1'b0);
        send_cell(8'hAB, 1'b0);
    endtask

    // Zero width and count, radius above range: clamped to a one-cell frame
    task automatic test_register_clamps();
        apply_config(9'd0, 9'd0, 3'd7, 1'b1);
        send_cell(8'h00, 1'b1);
        repeat (6) send_cell(8'($urandom), 1'b0);
    endtask

    // Disabled: cells are counted but nothing comes out
    task automatic test_disabled();
        apply_config(9'd2, 9'd2, 3'd1, 1'b0);
        send_cell(8'h5A, 1'b1);
        send_cell(8'h5A, 1'b0);
        send_cell(8'h5A, 1'b0);
    endtask

    // A new frame mid-stream drops the marks still owed to the old one
    task automatic test_frame_restart();
        apply_config(9'd1, 9'd8, 3'd2, 1'b1);
        send_cell(8'h77, 1'b1);
        send_cell(8'h77, 1'b0);
        send_cell(8'h77, 1'b0);
        send_cell(8'h77, 1'b1);
        send_cell(8'h77, 1'b0);
    endtask

    // Width above range clamps to the widest row; radius zero clamps to one
    task automatic test_wide_rows();
        apply_config(9'd511, 9'd3, 3'd0, 1'b1);
        send_cell(8'hA5, 1'b1);
        for (int k = 1; k < 320; k++)
            send_cell((k == 290) ? 8'h3C : (k == 300) ? 8'h00 : 8'hA5, 1'b0);
    endtask

    // Random geometry per phase; frames are mostly near-uniform so marks occur
    task automatic test_random_frames();
        int unsigned       x_raw, y_raw, r_raw, x, y, frame, length, guards, mode, noise_div;
        logic              en, first;
        logic [CELL_W-1:0] base, v;
        while (cells_sent < RANDOM_CELLS) begin
            x_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 16);
            y_raw = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 20);
            if ($urandom_range(0, 15) == 0) y_raw = $urandom_range(257, 511);
            r_raw = $urandom_range(0, 7);
            en = ($urandom_range(0, 7) != 0);
            apply_config(DIM_W'(x_raw), DIM_W'(y_raw), RADIUS_W'(r_raw), en);
            x = (x_raw == 0) ? 1 : x_raw;
            y = (y_raw == 0) ? 1 : y_raw;
            frame = x * y;
            repeat ($urandom_range(1, 3)) begin
                length = (frame > 240) ? 240 : frame;
                guards = $urandom_range(0, 6);
                mode = $urandom_range(0, 19);
                noise_div = 8 << (2 * $urandom_range(0, 3));
                base = $urandom;
                for (int unsigned k = 0; k < length + guards && cells_sent < RANDOM_CELLS;
                     k++) begin
                    if (mode < 12) begin
                        v = ($urandom_range(1, noise_div) == 1) ? 8'($urandom) : base;
                    end else if (mode < 17) begin
                        if ($urandom_range(0, 39) == 0) base = $urandom;
                        v = base;
                    end else begin
                        v = $urandom;
                    end
                    first = (k == 0) || ($urandom_range(0, 299) == 0);
                    if ($urandom_range(0, 199) == 0) wait_for_marks();
                    send_cell(v, first);
                end
            end
        end
    endtask

    // Output stall pattern: always ready, random, mostly ready, or a hard stall
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = (rx_mode == 3) ? $urandom_range(1, 16) : $urandom_range(8, 64);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= 1'b0;
        endcase
    end

    // Compare each beat on the output against the oldest expected mark
    always @(posedge aclk) begin : check_marks
        mark_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_marks.size() == 0) begin
                want = '0;
                note_mismatch("unexpected mark", want);
            end else begin
                want = pending_marks.pop_front();
                if (want.index !== m_cell_index || want.value !== m_mark_value)
                    note_mismatch("mark mismatch", want);
            end
        end
    end

    // End the run if neither channel moves a beat for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_edge_windows();
        test_register_clamps();
        test_disabled();
        test_frame_restart();
        test_wide_rows();
        test_random_frames();
        wait_for_marks();
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/uwm_pkg.sv
rtl/core/uwm_front.sv
rtl/core/uwm_queue.sv
rtl/core/uwm_back.sv
rtl/core/uniform_window_marker.sv
dv/uniform_window_marker_tb.sv
